// File: rtl/core/b2ssf_pkg.sv
// Shared constants and the digit-to-segment table for the seven-segment frame builder.
package b2ssf_pkg;

    localparam int NUMBER_W       = 27;
    localparam int ADDR_W         = 8;
    localparam int SEG_W          = 7;
    localparam int NUM_DIGITS_DEF = 8;

    localparam logic [ADDR_W-1:0] ADDR_BASE = 8'hC0;

    // q / 10 == (q * DIV10_RECIP) >> DIV10_SHIFT for any q below 2**32
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef logic [SEG_W-1:0] seg_t;

    // bit0 = segment a ... bit6 = segment g, point off
    function automatic seg_t seg_code(input logic [3:0] digit);
        seg_t code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/binary_to_seven_segment_frames_top.sv
// Binary number to seven-segment display frames: digit pipeline plus frame serializer.
//
//   channel | signals                                  | direction | per item
//   --------+------------------------------------------+-----------+--------------------------
//   input   | item_valid, item_ready, number           | in        | one number
//   output  | frame_valid, frame_ready, digit_address, | out       | one frame, NUM_DIGITS
//           | segments, last                           |           | frames per number
//
// One number enters per cycle while not stalled; it passes the input register, NUM_DIGITS
// divide-by-ten stages (one multiply each) and the serializer register to its first frame.
// The single output port, one frame per cycle while frame_ready is high, sets throughput;
// a new number is taken while earlier ones are still in flight.
// Reset clears all valid bits and the serializer; payload registers are not reset.
// A stall on frame_ready holds the current frame and backs up the pipeline stage by stage.
module binary_to_seven_segment_frames_top
    import b2ssf_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [NUMBER_W-1:0] number,
    output logic                frame_valid,
    input  logic                frame_ready,
    output logic [ADDR_W-1:0]   digit_address,
    output logic [SEG_W-1:0]    segments,
    output logic                last
);

    localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int SW = NUM_DIGITS * SEG_W;

    localparam logic [PW-1:0] LAST_CNT = PW'(NUM_DIGITS - 1);

    // stage 0 is the input register, stages 1..NUM_DIGITS extract one digit each
    logic                valid_reg [0:NUM_DIGITS];
    logic [NUMBER_W-1:0] q_reg     [0:NUM_DIGITS-1];
    logic [SW-1:0]       segs_reg  [1:NUM_DIGITS];
    logic [NUM_DIGITS+1:0] rdy;

    // serializer
    logic          busy_reg, busy_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] ser_segs_reg, ser_segs_next;
    logic          ser_free;
    logic          last_item;
    logic [PW-1:0] pos;

    // input stage
    assign rdy[0]     = !valid_reg[0] || rdy[1];
    assign item_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            valid_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            q_reg[0] <= number;
        end
    end

    // digit stages: stage i produces the digit of weight 10**(i-1)
    for (genvar i = 1; i <= NUM_DIGITS; i++)
    begin : g_digit
        logic [NUMBER_W+31:0] prod;
        logic [NUMBER_W-1:0]  quot;
        logic [NUMBER_W+2:0]  diff;
        logic [3:0]           rem;
        logic [SW-1:0]        segs_prev;
        logic [SW-1:0]        segs_next;

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        assign prod = {32'd0, q_reg[i-1]} * {{NUMBER_W{1'b0}}, DIV10_RECIP};
        assign quot = NUMBER_W'(prod >> DIV10_SHIFT);
        assign diff = {3'd0, q_reg[i-1]} - ({quot, 3'd0} + {2'd0, quot, 1'd0});
        assign rem  = diff[3:0];

        if (i == 1)
        begin : g_first
            assign segs_prev = '0;
        end
        else
        begin : g_rest
            assign segs_prev = segs_reg[i-1];
        end

        // blank once the remaining quotient is zero
        always_comb
        begin
            segs_next = segs_prev;
            segs_next[(i-1)*SEG_W +: SEG_W] =
                (q_reg[i-1] != '0) ? seg_code(rem) : '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                segs_reg[i] <= segs_next;
            end
        end

        if (i < NUM_DIGITS)
        begin : g_q
            logic [NUMBER_W-1:0] q_next;
            assign q_next = quot;

            always_ff @(posedge clk)
            begin
                if (rdy[i])
                begin
                    q_reg[i] <= q_next;
                end
            end
        end
    end

    // serializer: units digit first, at the highest position
    assign last_item = (cnt_reg == LAST_CNT);
    assign ser_free  = !busy_reg || (frame_ready && last_item);
    assign rdy[NUM_DIGITS+1] = ser_free;

    always_comb
    begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        ser_segs_next = ser_segs_reg;
        if (ser_free)
        begin
            busy_next     = valid_reg[NUM_DIGITS];
            cnt_next      = '0;
            ser_segs_next = segs_reg[NUM_DIGITS];
        end
        else if (frame_ready)
        begin
            cnt_next      = cnt_reg + PW'(1);
            ser_segs_next = ser_segs_reg >> SEG_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_segs_reg <= ser_segs_next;
    end

    assign pos           = LAST_CNT - cnt_reg;
    assign frame_valid   = busy_reg;
    assign segments      = ser_segs_reg[SEG_W-1:0];
    assign digit_address = ADDR_BASE + ADDR_W'({pos, 1'b0});
    assign last          = last_item;

`ifndef SYNTHESIS
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_BASE + ADDR_W'(2 * (NUM_DIGITS - 1));

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= LAST_CNT)
        else $error("frame counter out of range");

    a_new_frame_top: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && last |=> !frame_valid || digit_address == TOP_ADDR)
        else $error("frame sequence does not restart at the top position");

    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && !last
        |=> frame_valid && digit_address == $past(digit_address) - ADDR_W'(2))
        else $error("frame address did not step down by two");

    a_blank_stays: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && !last && segments == '0 |=> segments == '0)
        else $error("digit shown after a blank position");
`endif

endmodule

// File: bench/seg_frame_checker.sv
// Frame checker: predicts the NUM_DIGITS display frames of each accepted number and compares.
module seg_frame_checker
    import b2ssf_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic [NUMBER_W-1:0] number,
    input  logic                frame_valid,
    input  logic                frame_ready,
    input  logic [ADDR_W-1:0]   digit_address,
    input  logic [SEG_W-1:0]    segments,
    input  logic                last,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam seg_t DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        seg_t              seg;
        logic              last;
    } frame_t;

    frame_t expected_frames[$];

    // Units digit goes to the highest position; blank once the quotient runs out.
    function automatic void predict_frames(input logic [NUMBER_W-1:0] n);
        longint unsigned q;
        frame_t          f;
        q = n;
        for (int pos = NUM_DIGITS - 1; pos >= 0; pos--) begin
            f.seg = '0;
            if (q > 0) begin
                f.seg = DIGIT_SEG[int'(q % 10)];
                q = q / 10;
            end
            f.addr = ADDR_BASE + ADDR_W'(2 * pos);
            f.last = (pos == 0);
            expected_frames.push_back(f);
        end
    endfunction

    task automatic report_fail(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, what, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge clk) begin
        frame_t f;
        if (rst_n) begin
            if (item_valid && item_ready)
                predict_frames(number);
            if (frame_valid && frame_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, actual 0x%0h/0x%0h/%0b",
                             $time, digit_address, segments, last);
                    fail_count++;
                end
                else begin
                    f = expected_frames.pop_front();
                    if (digit_address !== f.addr)
                        report_fail("digit_address", f.addr, digit_address);
                    if (segments !== f.seg)
                        report_fail("segments", f.seg, segments);
                    if (last !== f.last)
                        report_fail("last", f.last, last);
                end
            end
            pending = expected_frames.size();
        end
    end

    final begin
    end

endmodule

// File: bench/binary_to_seven_segment_frames_top_tb.sv
// Testbench top: clock, reset, number stimulus, frame back-pressure and the verdict.
module binary_to_seven_segment_frames_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b2ssf_pkg::*;

    localparam int NUM_DIGITS   = NUM_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 300;

    localparam logic [NUMBER_W-1:0] DIRECTED_NUMBERS [19] = '{
        27'd0, 27'd1, 27'd5, 27'd9, 27'd10, 27'd90, 27'd101, 27'd1000,
        27'd10203040, 27'd80706050, 27'd12345678, 27'd87654321, 27'd9999999,
        27'd10000000, 27'd99999999, 27'd100000000, 27'd123456789,
        27'd67108864, 27'h7FFFFFF
    };

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [NUMBER_W-1:0] number;
    logic                frame_valid;
    logic                frame_ready;
    logic [ADDR_W-1:0]   digit_address;
    logic [SEG_W-1:0]    segments;
    logic                last;
    logic                number_taken;
    int                  fail_count;
    int                  pending;

    binary_to_seven_segment_frames_top #(.NUM_DIGITS(NUM_DIGITS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .number        (number),
        .frame_valid   (frame_valid),
        .frame_ready   (frame_ready),
        .digit_address (digit_address),
        .segments      (segments),
        .last          (last)
    );

    seg_frame_checker #(.NUM_DIGITS(NUM_DIGITS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .number        (number),
        .frame_valid   (frame_valid),
        .frame_ready   (frame_ready),
        .digit_address (digit_address),
        .segments      (segments),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // handshake sampled at the edge, looked at by the driver on the next falling edge
    always @(posedge clk)
        number_taken <= rst_n && item_valid && item_ready;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [NUMBER_W-1:0] pick_number();
        int unsigned   k;
        int unsigned   lim;
        int unsigned   v;
        case ($urandom_range(0, 9))
            0, 1: return NUMBER_W'($urandom);
            2:    return NUMBER_W'($urandom_range(100000000, (1 << NUMBER_W) - 1));
            3:    return NUMBER_W'($urandom_range(0, 99));
            4, 5: begin
                // decimal digits with many inner zeros
                v = 0;
                k = $urandom_range(1, NUM_DIGITS);
                for (int i = 0; i < k; i++)
                    v = v * 10 + (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 9));
                return NUMBER_W'(v);
            end
            default: begin
                k = $urandom_range(1, NUM_DIGITS);
                lim = 1;
                for (int i = 0; i < k; i++)
                    lim = lim * 10;
                return NUMBER_W'($urandom_range(0, lim - 1));
            end
        endcase
    endfunction

    // called on a falling edge; returns on the falling edge after acceptance, or after the idle gap
    task automatic send_number(input logic [NUMBER_W-1:0] n, input int gap);
        item_valid <= 1'b1;
        number     <= n;
        do
            @(negedge clk);
        while (!number_taken);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // frame back-pressure: long free-running stretches, otherwise random stalls
    initial begin
        int run;
        frame_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0) begin
                frame_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge clk);
            end
            else begin
                run = $urandom_range(1, 6);
                frame_ready <= 1'b1;
                repeat (run) @(negedge clk);
                frame_ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge clk);
            end
        end
    end

    initial begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        number     = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (DIRECTED_NUMBERS[i])
            send_number(DIRECTED_NUMBERS[i], 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_number(pick_number(), (i < 40) ? 0 : pick_gap());
        item_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (4 * NUM_DIGITS + 8) @(negedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: binary_to_seven_segment_frames_top.f
rtl/core/b2ssf_pkg.sv
rtl/core/binary_to_seven_segment_frames_top.sv
bench/seg_frame_checker.sv
bench/binary_to_seven_segment_frames_top_tb.sv
